[design/sdaf_pkg.sv]
// Shared constants and types for the signed decimal ASCII formatter.
package sdaf_pkg;

  // Input word width and number of decimal digits held
  localparam int VALUE_W   = 32;
  localparam int MAX_DIGITS = 10;
  localparam int BCD_W     = 4 * MAX_DIGITS;
  localparam int CHAR_W    = 6;

  // Counter widths
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

[design/sdaf_in_if.sv]
// Input channel: one signed value per item.
interface sdaf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdaf_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[design/sdaf_out_if.sv]
// Result channel: one ASCII character per item.
interface sdaf_out_if;
  logic                         valid;
  logic                         ready;
  logic [sdaf_pkg::CHAR_W-1:0]  ascii_char;
  logic                         last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

[design/signed_decimal_ascii_formatter.sv]
// Top level: signed integer to decimal ASCII character stream.
//
// Each accepted value is converted with a bit-serial shift-and-add-3 loop,
// one input bit per cycle, into a ten-digit BCD shift register.
// Leading zero digits are then shifted out at one per cycle without output,
// and the characters follow at one per cycle while the sink is ready: a
// minus sign for a negative value, then the digits, most significant first,
// with last_char on the final one. A run is the accept, the conversion, the
// leading zero skip with its exit step, the sign for a negative value and the
// digits, plus any output stall.
// A new value is accepted only once the previous run has been fully taken.
module signed_decimal_ascii_formatter (
  input  logic       clk,
  input  logic       rst_n,
  sdaf_in_if.sink    in_if,
  sdaf_out_if.source out_if
);

  localparam int BCD_W = sdaf_pkg::BCD_W;

  sdaf_pkg::state_t                state_r, state_nxt;
  logic [sdaf_pkg::VALUE_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]                bcd_r, bcd_nxt;
  logic [sdaf_pkg::BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [sdaf_pkg::DIG_CNT_W-1:0]  dig_cnt_r, dig_cnt_nxt;
  logic                            neg_r, neg_nxt;
  logic                            ovf_r, ovf_nxt;

  logic [BCD_W-1:0]                bcd_adj;
  logic [3:0]                      top_digit;
  logic                            in_fire;
  logic                            out_fire;

  assign in_fire   = in_if.valid && in_if.ready;
  assign out_fire  = out_if.valid && out_if.ready;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // Add 3 to every digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < sdaf_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Handshake and character output
  assign in_if.ready = (state_r == sdaf_pkg::ST_IDLE);
  assign out_if.valid = (state_r == sdaf_pkg::ST_SIGN) || (state_r == sdaf_pkg::ST_EMIT);
  assign out_if.ascii_char = (state_r == sdaf_pkg::ST_SIGN) ? sdaf_pkg::CHAR_MINUS :
                             (sdaf_pkg::CHAR_ZERO + {2'b00, top_digit});
  assign out_if.last_char = (state_r == sdaf_pkg::ST_EMIT) &&
                            (dig_cnt_r == sdaf_pkg::DIG_CNT_W'(1));

  // Next state and datapath
  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    neg_nxt     = neg_r;
    ovf_nxt     = ovf_r;
    case (state_r)
      sdaf_pkg::ST_IDLE: begin
        if (in_fire) begin
          neg_nxt     = in_if.value[sdaf_pkg::VALUE_W-1];
          // unsigned negate gives the right magnitude for the most negative value
          bin_nxt     = in_if.value[sdaf_pkg::VALUE_W-1] ?
                        (~in_if.value + sdaf_pkg::VALUE_W'(1)) : in_if.value;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = sdaf_pkg::ST_CONV;
        end
      end
      sdaf_pkg::ST_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[sdaf_pkg::VALUE_W-1]};
        bin_nxt     = bin_r << 1;
        // a bit leaving the top digit means more digits than the buffer holds
        ovf_nxt     = ovf_r | bcd_adj[BCD_W-1];
        bit_cnt_nxt = bit_cnt_r + sdaf_pkg::BIT_CNT_W'(1);
        if (bit_cnt_r == sdaf_pkg::BIT_CNT_W'(sdaf_pkg::VALUE_W - 1)) begin
          dig_cnt_nxt = sdaf_pkg::DIG_CNT_W'(sdaf_pkg::MAX_DIGITS);
          state_nxt   = sdaf_pkg::ST_SKIP;
        end
      end
      sdaf_pkg::ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (!ovf_r && (top_digit == 4'd0) && (dig_cnt_r != sdaf_pkg::DIG_CNT_W'(1))) begin
          bcd_nxt     = bcd_r << 4;
          dig_cnt_nxt = dig_cnt_r - sdaf_pkg::DIG_CNT_W'(1);
        end else if (neg_r) begin
          state_nxt = sdaf_pkg::ST_SIGN;
        end else begin
          state_nxt = sdaf_pkg::ST_EMIT;
        end
      end
      sdaf_pkg::ST_SIGN: begin
        if (out_fire) begin
          state_nxt = sdaf_pkg::ST_EMIT;
        end
      end
      sdaf_pkg::ST_EMIT: begin
        if (out_fire) begin
          bcd_nxt     = bcd_r << 4;
          dig_cnt_nxt = dig_cnt_r - sdaf_pkg::DIG_CNT_W'(1);
          if (dig_cnt_r == sdaf_pkg::DIG_CNT_W'(1)) begin
            state_nxt = sdaf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sdaf_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdaf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    neg_r     <= neg_nxt;
    ovf_r     <= ovf_nxt;
  end

  // Checks
  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == sdaf_pkg::ST_CONV) && (bit_cnt_r == '0))
    else $error("accepted item did not start conversion");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_if.last_char) |=> (state_r == sdaf_pkg::ST_IDLE))
    else $error("run did not end after last character");

  a_digit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdaf_pkg::ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("emitted digit out of range");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !in_if.ready)
    else $error("input taken while characters pending");

endmodule
